/* hw/rtl/bfbl_pkg.sv */
// Shared types and constants for the best-fit free block table.
package bfbl_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int POS_W         = 8;
    localparam int VAL_W         = 31;
    localparam int ENTRY_W       = 2 * VAL_W;
    localparam int CNT_OUT_W     = 9;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_POP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_EXACT = 2'd0,
        ST_CLAMP = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOFIT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_PUT,
        S_DN_RD,
        S_DN_WR,
        S_RD_REQ,
        S_RD_WAIT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        mode_t              mode;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   block_offset;
        logic [VAL_W-1:0]   block_size;
        logic [VAL_W-1:0]   request_size;
    } item_t;

    typedef struct packed {
        status_t                status;
        logic [VAL_W-1:0]       found_offset;
        logic [VAL_W-1:0]       found_size;
        logic [CNT_OUT_W-1:0]   entry_count;
    } res_t;

endpackage

/* hw/rtl/best_fit_free_block_list.sv */
// One item is worked at a time. Insert shifts the entries from the insert index up by one
// and then writes the new entry; delete shifts the entries above its index down by one; read
// fetches one entry; pop scans every entry, then removes the best fit with the delete shift.
// Full inserts and empty deletes or reads go straight to the result, without table access.
// A finished result waits in the output register while the next beat is accepted.
// Reset clears the entry count and control state; the table RAM is not cleared.
module best_fit_free_block_list #(
    parameter int DEPTH = bfbl_pkg::DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[1:0], position[9:2], block_offset[40:10], block_size[71:41],
    // request_size[102:72], zero pad[103]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], found_offset[32:2], found_size[63:33], entry_count[72:64],
    // zero pad[79:73]
    output logic [79:0]  m_tdata
);
    import bfbl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    item_t              item;
    res_t               res;
    logic               res_valid;
    logic               res_ready;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               m_tvalid_reg, m_tvalid_next;
    res_t               out_reg, out_next;

    assign item.mode         = mode_t'(s_tdata[1:0]);
    assign item.position     = s_tdata[9:2];
    assign item.block_offset = s_tdata[40:10];
    assign item.block_size   = s_tdata[71:41];
    assign item.request_size = s_tdata[102:72];

    bfbl_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    bfbl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_reg.entry_count, out_reg.found_size,
                       out_reg.found_offset, out_reg.status};

endmodule

/* hw/rtl/bfbl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bfbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/bfbl_ctrl.sv */
// Sequencer that shifts, reads and scans the free block table one entry at a time.
module bfbl_ctrl #(
    parameter int DEPTH = bfbl_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bfbl_pkg::item_t           item,
    output logic                      res_valid,
    input  logic                      res_ready,
    output bfbl_pkg::res_t            res,
    output logic                      ram_we,
    output logic [AW-1:0]             ram_waddr,
    output logic [bfbl_pkg::ENTRY_W-1:0] ram_wdata,
    output logic                      ram_re,
    output logic [AW-1:0]             ram_raddr,
    input  logic [bfbl_pkg::ENTRY_W-1:0] ram_rdata
);
    import bfbl_pkg::*;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      best_reg, best_next;
    logic               have_reg, have_next;
    status_t            status_reg, status_next;
    logic [VAL_W-1:0]   fo_reg, fo_next;
    logic [VAL_W-1:0]   fs_reg, fs_next;
    logic [VAL_W-1:0]   boff_reg, boff_next;
    logic [VAL_W-1:0]   bsize_reg, bsize_next;
    logic [VAL_W-1:0]   req_reg, req_next;

    logic [CNT_OUT_W-1:0] count9;
    logic [CNT_OUT_W-1:0] pos9;
    logic [CNT_OUT_W-1:0] last9;
    logic [CNT_OUT_W-1:0] ins_idx9;
    logic [CNT_OUT_W-1:0] lst_idx9;
    logic [CW:0]          ptr_inc;
    logic [VAL_W-1:0]     rd_off;
    logic [VAL_W-1:0]     rd_size;

    assign count9   = CNT_OUT_W'(count_reg);
    assign pos9     = CNT_OUT_W'(item.position);
    assign last9    = count9 - CNT_OUT_W'(1);
    assign ins_idx9 = (pos9 < count9) ? pos9 : count9;
    assign lst_idx9 = (pos9 < last9) ? pos9 : last9;
    assign ptr_inc  = (CW + 1)'(ptr_reg) + (CW + 1)'(1);
    assign rd_off   = ram_rdata[ENTRY_W-1:VAL_W];
    assign rd_size  = ram_rdata[VAL_W-1:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.status       = status_reg;
    assign res.found_offset = fo_reg;
    assign res.found_size   = fs_reg;
    assign res.entry_count  = count9;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        idx_reg    <= idx_next;
        best_reg   <= best_next;
        have_reg   <= have_next;
        status_reg <= status_next;
        fo_reg     <= fo_next;
        fs_reg     <= fs_next;
        boff_reg   <= boff_next;
        bsize_reg  <= bsize_next;
        req_reg    <= req_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        idx_next    = idx_reg;
        best_next   = best_reg;
        have_next   = have_reg;
        status_next = status_reg;
        fo_next     = fo_reg;
        fs_next     = fs_reg;
        boff_next   = boff_reg;
        bsize_next  = bsize_reg;
        req_next    = req_reg;
        ram_we      = 1'b0;
        ram_waddr   = AW'(ptr_reg);
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = AW'(ptr_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    fo_next    = '0;
                    fs_next    = '0;
                    have_next  = 1'b0;
                    boff_next  = item.block_offset;
                    bsize_next = item.block_size;
                    req_next   = item.request_size;
                    case (item.mode)
                        MODE_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                idx_next    = CW'(ins_idx9);
                                ptr_next    = count_reg;
                                status_next = (ins_idx9 == pos9) ? ST_EXACT : ST_CLAMP;
                                state_next  = S_UP_RD;
                            end
                        end
                        MODE_DELETE, MODE_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_CLAMP;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ptr_next    = CW'(lst_idx9);
                                status_next = (lst_idx9 == pos9) ? ST_EXACT : ST_CLAMP;
                                state_next  = (item.mode == MODE_DELETE) ? S_DN_RD : S_RD_REQ;
                            end
                        end
                        default:
                        begin
                            ptr_next   = '0;
                            state_next = S_SCAN_RD;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                if (ptr_reg > idx_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(ptr_reg - CW'(1));
                    state_next = S_UP_WR;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_UP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(ptr_reg);
                ram_wdata  = ram_rdata;
                ptr_next   = ptr_reg - CW'(1);
                state_next = S_UP_RD;
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(idx_reg);
                ram_wdata  = {boff_reg, bsize_reg};
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_DN_RD:
            begin
                if (ptr_inc < (CW + 1)'(count_reg))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(ptr_inc);
                    state_next = S_DN_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_DN_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(ptr_reg);
                ram_wdata  = ram_rdata;
                ptr_next   = CW'(ptr_inc);
                state_next = S_DN_RD;
            end
            S_RD_REQ:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(ptr_reg);
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                fo_next    = rd_off;
                fs_next    = rd_size;
                state_next = S_DONE;
            end
            S_SCAN_RD:
            begin
                if (ptr_reg < count_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(ptr_reg);
                    state_next = S_SCAN_CMP;
                end
                else if (have_reg)
                begin
                    // The winner is removed through the same shift-down path as delete.
                    status_next = ST_EXACT;
                    ptr_next    = best_reg;
                    state_next  = S_DN_RD;
                end
                else
                begin
                    status_next = ST_NOFIT;
                    state_next  = S_DONE;
                end
            end
            S_SCAN_CMP:
            begin
                // Strict less-than keeps the earliest entry on a tie.
                if ((rd_size >= req_reg) && (!have_reg || (rd_size < fs_reg)))
                begin
                    have_next = 1'b1;
                    best_next = ptr_reg;
                    fo_next   = rd_off;
                    fs_next   = rd_size;
                end
                ptr_next   = CW'(ptr_inc);
                state_next = S_SCAN_RD;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/bfbl_checker.sv */
// Port-level checker for the free block table, bound to the top level.
module bfbl_checker #(
    parameter int DEPTH = bfbl_pkg::DEPTH_DEFAULT
) (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [79:0]  m_tdata
);
    import bfbl_pkg::*;

    // Only one item is worked at a time, so the input closes right after a beat.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still open after an accepted beat");

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[72:64] <= CNT_OUT_W'(DEPTH)))
        else $error("entry count exceeds table depth");

    // A full report only comes from a full table and carries no block.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == ST_FULL)) |->
        ((m_tdata[72:64] == CNT_OUT_W'(DEPTH)) && (m_tdata[63:2] == '0)))
        else $error("full status with wrong count or nonzero block");

    a_nofit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == ST_NOFIT)) |-> (m_tdata[63:2] == '0))
        else $error("no-fit status with nonzero block");

endmodule

bind best_fit_free_block_list bfbl_checker #(.DEPTH(DEPTH)) u_bfbl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
